// ===== rtl/olid_pkg.sv =====
// shared types, codes and sizes for the ordered list block
`timescale 1ns / 1ps
`default_nettype none

package olid_pkg;

   // list size
   localparam int CAPACITY_DEF = 16;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = 1;

   // operation codes of an input item
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_DELETE = 2'd1;
   localparam logic [1:0] OP_LIST   = 2'd2;

   // result status codes
   localparam logic [2:0] ST_INSERTED  = 3'd0;
   localparam logic [2:0] ST_FULL      = 3'd1;
   localparam logic [2:0] ST_DELETED   = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND = 3'd3;
   localparam logic [2:0] ST_EMPTY     = 3'd4;
   localparam logic [2:0] ST_FORWARD   = 3'd5;
   localparam logic [2:0] ST_BACKWARD  = 3'd6;

   // input item
   typedef struct packed {
      logic [1:0]         opcode;
      logic signed [31:0] operand_value;
   } req_type;

   // result item
   typedef struct packed {
      logic [2:0]         status;
      logic signed [31:0] entry_value;
      logic               last;
   } rsp_type;

   // classified command held in the queue
   typedef struct packed {
      logic [1:0]         kind;
      logic signed [31:0] value;
   } cmd_type;

   // queue handshake toward the back end
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_out_type;

endpackage

`default_nettype wire

// ===== rtl/olid_ram.sv =====
// generic simple dual port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module olid_ram #(
   parameter  int WIDTH = 32,
   parameter  int DEPTH = 16,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [AW-1:0]             wr_addr,
   input  wire logic [WIDTH-1:0]          wr_data,
   input  wire logic [AW-1:0]             rd_addr,
   output logic      [WIDTH-1:0]          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/olid_front.sv =====
// front end: takes items, drops unused opcodes, queues commands for the back end
`timescale 1ns / 1ps
`default_nettype none

module olid_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire olid_pkg::req_type  req_item,
   input  wire logic               q_pop,
   output logic                    busy,
   output olid_pkg::queue_out_type q_out
);

   olid_pkg::cmd_type                slot_ff [olid_pkg::QUEUE_DEPTH];
   logic [olid_pkg::QUEUE_AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [olid_pkg::QUEUE_AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [olid_pkg::QUEUE_AW:0]      fill_ff, fill_in;
   logic                             accept;
   logic                             known_op;
   logic                             push;

   // classify: only insert, delete and list reach the back end
   always_comb begin
      unique case (req_item.opcode)
         olid_pkg::OP_INSERT,
         olid_pkg::OP_DELETE,
         olid_pkg::OP_LIST:   known_op = 1'b1;
         default:             known_op = 1'b0;
      endcase
   end

   assign busy   = (fill_ff == (olid_pkg::QUEUE_AW + 1)'(olid_pkg::QUEUE_DEPTH));
   assign accept = start && !busy;
   assign push   = accept && known_op;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      priority if (push && !q_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (q_pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end else begin
         fill_in = fill_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // queue slots hold payload only
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= '{kind: req_item.opcode, value: req_item.operand_value};
      end
   end

   assign q_out.valid = (fill_ff != '0);
   assign q_out.cmd   = slot_ff[rd_ptr_ff];

endmodule

`default_nettype wire

// ===== rtl/olid_back.sv =====
// back end: runs insert, delete and list against the entry store
`timescale 1ns / 1ps
`default_nettype none

module olid_back #(
   parameter int CAPACITY = olid_pkg::CAPACITY_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire olid_pkg::queue_out_type q_out,
   output logic                         q_pop,
   output logic                         rsp_strobe,
   output olid_pkg::rsp_type            rsp_item
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   // sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SRCH  = 3'd1;
   localparam logic [2:0] S_SHIFT = 3'd2;
   localparam logic [2:0] S_FWD   = 3'd3;
   localparam logic [2:0] S_BWD   = 3'd4;

   logic [2:0]         state_ff, state_in;
   logic               phase_ff, phase_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [CW-1:0]      count_ff, count_in;
   logic signed [31:0] val_ff, val_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   olid_pkg::rsp_type  rsp_item_ff, rsp_item_in;

   logic [CW-1:0]      idx_nx, idx_nx2, idx_dn;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [31:0]        wr_data;
   logic [AW-1:0]      rd_addr;
   logic [31:0]        rd_data;

   assign idx_nx  = idx_ff + CW'(1);
   assign idx_nx2 = idx_ff + CW'(2);
   assign idx_dn  = idx_ff - CW'(1);

   // entry store
   olid_ram #(
      .WIDTH (32),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // read address: phase 0 issues, phase 1 uses the data
   always_comb begin
      unique case (state_ff)
         S_SHIFT: rd_addr = idx_nx[AW-1:0];
         S_BWD:   rd_addr = idx_dn[AW-1:0];
         default: rd_addr = idx_ff[AW-1:0];
      endcase
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      val_in        = val_ff;
      q_pop         = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = count_ff[AW-1:0];
      wr_data       = q_out.cmd.value;
      rsp_strobe_in = 1'b0;
      rsp_item_in   = '{status: olid_pkg::ST_INSERTED, entry_value: val_ff, last: 1'b1};

      unique case (state_ff)
         S_IDLE: begin
            if (q_out.valid) begin
               q_pop                   = 1'b1;
               val_in                  = q_out.cmd.value;
               idx_in                  = '0;
               phase_in                = 1'b0;
               rsp_item_in.entry_value = q_out.cmd.value;
               unique case (q_out.cmd.kind)
                  olid_pkg::OP_INSERT: begin
                     rsp_strobe_in = 1'b1;
                     if (count_ff == CW'(CAPACITY)) begin
                        rsp_item_in.status = olid_pkg::ST_FULL;
                     end else begin
                        rsp_item_in.status = olid_pkg::ST_INSERTED;
                        wr_en              = 1'b1;
                        count_in           = count_ff + CW'(1);
                     end
                  end
                  olid_pkg::OP_DELETE: begin
                     if (count_ff == '0) begin
                        rsp_strobe_in      = 1'b1;
                        rsp_item_in.status = olid_pkg::ST_EMPTY;
                     end else begin
                        state_in = S_SRCH;
                     end
                  end
                  olid_pkg::OP_LIST: begin
                     if (count_ff == '0) begin
                        rsp_strobe_in      = 1'b1;
                        rsp_item_in.status = olid_pkg::ST_EMPTY;
                     end else begin
                        state_in = S_FWD;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         // compare entries one at a time from the head: phase 0 issues the read, phase 1 compares
         S_SRCH: begin
            phase_in = !phase_ff;
            if (phase_ff) begin
               priority if (rd_data == val_ff && idx_nx == count_ff) begin
                  count_in           = count_ff - CW'(1);
                  rsp_strobe_in      = 1'b1;
                  rsp_item_in.status = olid_pkg::ST_DELETED;
                  state_in           = S_IDLE;
               end else if (rd_data == val_ff) begin
                  state_in = S_SHIFT;
               end else if (idx_nx == count_ff) begin
                  rsp_strobe_in      = 1'b1;
                  rsp_item_in.status = olid_pkg::ST_NOT_FOUND;
                  state_in           = S_IDLE;
               end else begin
                  idx_in = idx_nx;
               end
            end
         end

         // move each later entry one place toward the head
         S_SHIFT: begin
            phase_in = !phase_ff;
            if (phase_ff) begin
               wr_en   = 1'b1;
               wr_addr = idx_ff[AW-1:0];
               wr_data = rd_data;
               if (idx_nx2 < count_ff) begin
                  idx_in = idx_nx;
               end else begin
                  count_in           = count_ff - CW'(1);
                  rsp_strobe_in      = 1'b1;
                  rsp_item_in.status = olid_pkg::ST_DELETED;
                  state_in           = S_IDLE;
               end
            end
         end

         // head to tail
         S_FWD: begin
            phase_in = !phase_ff;
            if (phase_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_item_in   = '{status: olid_pkg::ST_FORWARD, entry_value: rd_data,
                                 last: 1'b0};
               if (idx_nx == count_ff) begin
                  idx_in   = count_ff;
                  state_in = S_BWD;
               end else begin
                  idx_in = idx_nx;
               end
            end
         end

         // tail to head, last result at the head
         S_BWD: begin
            phase_in = !phase_ff;
            if (phase_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_item_in   = '{status: olid_pkg::ST_BACKWARD, entry_value: rd_data,
                                 last: (idx_ff == CW'(1))};
               if (idx_ff == CW'(1)) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in = idx_dn;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
            phase_in = 1'b0;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         phase_ff      <= 1'b0;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      val_ff      <= val_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

endmodule

`default_nettype wire

// ===== rtl/ordered_list_insert_delete.sv =====
// Insert and empty/full results need no store access; they go out through the result register
// when the idle back end pops the item. A delete searches entries from the head and then moves
// each later entry one place toward the head; a list gives every entry head to tail, then tail
// to head, one store read per result. The back end takes no new item until a delete or a list
// is done. Up to two items queue in front; busy is high when the queue is full.
// Reset clears the entry count, the queue and the strobe; the store itself is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module ordered_list_insert_delete #(
   parameter int CAPACITY = olid_pkg::CAPACITY_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire olid_pkg::req_type req_item,
   output logic                   rsp_strobe,
   output olid_pkg::rsp_type      rsp_item
);

   olid_pkg::queue_out_type q_out;
   logic                    q_pop;

   // accept and queue
   olid_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_item (req_item),
      .q_pop    (q_pop),
      .busy     (busy),
      .q_out    (q_out)
   );

   // execute
   olid_back #(
      .CAPACITY (CAPACITY)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_out      (q_out),
      .q_pop      (q_pop),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule

`default_nettype wire

// ===== rtl/olid_chk.sv =====
// port level checks for the ordered list block and their bind
`timescale 1ns / 1ps
`default_nettype none

module olid_chk (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              busy,
   input wire logic              rsp_strobe,
   input wire olid_pkg::rsp_type rsp_item
);

   // nothing pending right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> (!rsp_strobe && !busy))
      else $error("strobe or busy after reset");

   // only listed entries may be non-final
   a_single_final: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.status != olid_pkg::ST_FORWARD
                  && rsp_item.status != olid_pkg::ST_BACKWARD) |-> rsp_item.last)
      else $error("single result item without last");

   a_forward_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.status == olid_pkg::ST_FORWARD) |-> !rsp_item.last)
      else $error("forward entry marked last");

   // a listing runs on with forward or backward results until its last result
   a_list_cadence: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_item.last) |-> ##2 (rsp_strobe &&
         (rsp_item.status == olid_pkg::ST_FORWARD ||
          rsp_item.status == olid_pkg::ST_BACKWARD)))
      else $error("listing broke off");

   // back end busy with a listing never returns a short result meanwhile
   a_list_no_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_item.last) |=> !rsp_strobe)
      else $error("result between listed entries");

endmodule

bind ordered_list_insert_delete olid_chk u_olid_chk (.*);

`default_nettype wire
